>>> src/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define QVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define QVT_ASSERT(lbl, clk, rstn, prop, msg)
`define QVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> src/qvt_pkg.sv
package qvt_pkg;

  localparam int DIV_BITS   = 64;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
  localparam int DVS_W      = 33;

  typedef enum logic [2:0] {
    REG_QUAT_W      = 3'd0,
    REG_QUAT_X      = 3'd1,
    REG_QUAT_Y      = 3'd2,
    REG_QUAT_Z      = 3'd3,
    REG_VIEW_SCALE  = 3'd4,
    REG_PERSPECTIVE = 3'd5,
    REG_FOCAL       = 3'd6,
    REG_EYE_DIST    = 3'd7
  } qvt_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } qvt_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_z;
    logic               saturated;
  } qvt_out_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic        [31:0] view_scale;
    logic               perspective_on;
    logic signed [31:0] focal_length;
    logic signed [31:0] eye_distance;
  } qvt_cfg_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               flag;
  } qvt_rot_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic               flag;
    logic               persp;
    logic signed [63:0] num_x;
    logic signed [63:0] num_y;
    logic signed [32:0] denom;
  } qvt_proj_t;

  typedef struct packed {
    logic               vld;
    logic [DVS_W-1:0]   rem;
    logic [DIV_BITS-1:0] dvd;
    logic [DIV_BITS-1:0] quo;
    logic [DVS_W-1:0]   dvs;
  } qvt_div_t;

  // {flag, value}
  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < -68'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

endpackage

>>> src/quaternion_vertex_transform.sv
// Quaternion vertex transform.
// Input: a point (point_i) is transferred at a rising edge with start high
// and busy low. busy is always low: a point may enter every cycle.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (quat w/x/y/z, view scale, perspective on, focal length, eye distance);
// write only while no point is in flight.
// Output: result_valid_o is high for exactly one cycle with result_o; the
// receiver must take it then, it cannot stall the block.
// Pipeline: 24 register stages (4 rotate stages, 3 scale/projection
// stages, 16 divider stages of 4 quotient bits each, 1 output
// register).
// Throughput: one point per cycle, set by the fully pipelined divider.
// Reset: all valid bits clear, registers return to identity rotation,
// unit scale, orthographic mode, focus and distance of 1.0.
// Matrix terms follow a cfg write via the product and matrix registers.
`include "assert_macros.svh"

module quaternion_vertex_transform import qvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  qvt_in_t     point_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output qvt_out_t    result_o
);

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic               flag;
    logic               persp;
    logic               zero;
    logic               qneg_x;
    logic               qneg_y;
    logic               nneg_x;
    logic               nneg_y;
    logic               nzero_x;
    logic               nzero_y;
  } side_t;

  qvt_cfg_t  cfg_q;
  qvt_rot_t  rot;
  qvt_proj_t proj;
  qvt_div_t  dx [DIV_STAGES+1];
  qvt_div_t  dy [DIV_STAGES+1];
  side_t     side0;
  side_t     side_q [DIV_STAGES];
  side_t     sl;
  logic [DVS_W-1:0] dvs_abs;
  logic [32:0] qx_s, qy_s;
  qvt_out_t  res_d, res_q;
  logic      valid_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quat_w         <= 16'sd16384;
      cfg_q.quat_x         <= '0;
      cfg_q.quat_y         <= '0;
      cfg_q.quat_z         <= '0;
      cfg_q.view_scale     <= 32'd65536;
      cfg_q.perspective_on <= 1'b0;
      cfg_q.focal_length   <= 32'sd65536;
      cfg_q.eye_distance   <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (qvt_reg_e'(cfg_idx_i))
        REG_QUAT_W:      cfg_q.quat_w         <= cfg_data_i[15:0];
        REG_QUAT_X:      cfg_q.quat_x         <= cfg_data_i[15:0];
        REG_QUAT_Y:      cfg_q.quat_y         <= cfg_data_i[15:0];
        REG_QUAT_Z:      cfg_q.quat_z         <= cfg_data_i[15:0];
        REG_VIEW_SCALE:  cfg_q.view_scale     <= cfg_data_i;
        REG_PERSPECTIVE: cfg_q.perspective_on <= cfg_data_i[0];
        REG_FOCAL:       cfg_q.focal_length   <= cfg_data_i;
        REG_EYE_DIST:    cfg_q.eye_distance   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qvt_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .vld_i   (start & ~busy),
    .point_i (point_i),
    .rot_o   (rot)
  );

  qvt_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .rot_i  (rot),
    .proj_o (proj)
  );

  assign dvs_abs = proj.denom[32] ? DVS_W'(-proj.denom) : DVS_W'(proj.denom);

  always_comb begin
    dx[0].vld = proj.vld;
    dx[0].rem = '0;
    dx[0].dvd = proj.num_x[63] ? DIV_BITS'(-proj.num_x) : DIV_BITS'(proj.num_x);
    dx[0].quo = '0;
    dx[0].dvs = dvs_abs;
    dy[0].vld = proj.vld;
    dy[0].rem = '0;
    dy[0].dvd = proj.num_y[63] ? DIV_BITS'(-proj.num_y) : DIV_BITS'(proj.num_y);
    dy[0].quo = '0;
    dy[0].dvs = dvs_abs;

    side0.rx      = proj.rx;
    side0.ry      = proj.ry;
    side0.rz      = proj.rz;
    side0.sx      = proj.sx;
    side0.sy      = proj.sy;
    side0.sz      = proj.sz;
    side0.flag    = proj.flag;
    side0.persp   = proj.persp;
    side0.zero    = (proj.denom == '0);
    side0.qneg_x  = proj.num_x[63] ^ proj.denom[32];
    side0.qneg_y  = proj.num_y[63] ^ proj.denom[32];
    side0.nneg_x  = proj.num_x[63];
    side0.nneg_y  = proj.num_y[63];
    side0.nzero_x = (proj.num_x == '0);
    side0.nzero_y = (proj.num_y == '0);
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    qvt_div_stage u_div_x (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (dx[g]),
      .d_o    (dx[g+1])
    );
    qvt_div_stage u_div_y (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (dy[g]),
      .d_o    (dy[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  assign sl = side_q[DIV_STAGES-1];

  function automatic logic [32:0] qsat(input logic [DIV_BITS-1:0] mag, input logic neg);
    if (neg) begin
      if (mag > DIV_BITS'(64'd2147483648)) begin
        return {1'b1, 32'h80000000};
      end else begin
        return {1'b0, 32'(-mag)};
      end
    end else begin
      if (mag > DIV_BITS'(64'd2147483647)) begin
        return {1'b1, 32'h7fffffff};
      end else begin
        return {1'b0, mag[31:0]};
      end
    end
  endfunction

  assign qx_s = qsat(dx[DIV_STAGES].quo, sl.qneg_x);
  assign qy_s = qsat(dy[DIV_STAGES].quo, sl.qneg_y);

  always_comb begin
    res_d.rotated_x = sl.rx;
    res_d.rotated_y = sl.ry;
    res_d.rotated_z = sl.rz;
    res_d.screen_x  = sl.sx;
    res_d.screen_y  = sl.sy;
    res_d.screen_z  = sl.sz;
    res_d.saturated = sl.flag;
    if (sl.persp) begin
      if (sl.zero) begin
        res_d.saturated = 1'b1;
        res_d.screen_x  = sl.nzero_x ? 32'sd0 : (sl.nneg_x ? 32'h80000000 : 32'h7fffffff);
        res_d.screen_y  = sl.nzero_y ? 32'sd0 : (sl.nneg_y ? 32'h80000000 : 32'h7fffffff);
      end else begin
        res_d.screen_x  = qx_s[31:0];
        res_d.screen_y  = qy_s[31:0];
        res_d.saturated = sl.flag | qx_s[32] | qy_s[32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dx[DIV_STAGES].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  `QVT_ASSERT(a_strobe_src, clk_i, rst_ni, result_valid_o |-> $past(dx[DIV_STAGES].vld), "strobe without divider output")
  `QVT_ASSERT_NEXT(a_lanes_aligned, clk_i, rst_ni, dx[DIV_STAGES].vld && !sl.persp, result_o.screen_x == $past(sl.sx), "orthographic x mismatch")
  `QVT_ASSERT(a_lane_valid, clk_i, rst_ni, dx[DIV_STAGES].vld == dy[DIV_STAGES].vld, "divider lanes out of step")

endmodule

>>> src/qvt_rotate.sv
module qvt_rotate import qvt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  qvt_cfg_t cfg_i,
  input  logic     vld_i,
  input  qvt_in_t  point_i,
  output qvt_rot_t rot_o
);

  localparam logic signed [35:0] ONE = 36'sd268435456;

  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [35:0] m28 [3][3];
  logic signed [31:0] m_q [3][3];
  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] p1_q [3];
  logic signed [31:0] p2_q [3];
  logic signed [63:0] pp_q [3][3];
  logic signed [65:0] acc [3];
  logic signed [65:0] sh [3];
  logic        [32:0] sat [3];
  qvt_rot_t           rot_q;

  always_ff @(posedge clk_i) begin
    xx_q <= cfg_i.quat_x * cfg_i.quat_x;
    yy_q <= cfg_i.quat_y * cfg_i.quat_y;
    zz_q <= cfg_i.quat_z * cfg_i.quat_z;
    xy_q <= cfg_i.quat_x * cfg_i.quat_y;
    xz_q <= cfg_i.quat_x * cfg_i.quat_z;
    yz_q <= cfg_i.quat_y * cfg_i.quat_z;
    xw_q <= cfg_i.quat_x * cfg_i.quat_w;
    yw_q <= cfg_i.quat_y * cfg_i.quat_w;
    zw_q <= cfg_i.quat_z * cfg_i.quat_w;
  end

  always_comb begin
    m28[0][0] = ONE - ((36'(yy_q) + 36'(zz_q)) <<< 1);
    m28[0][1] = (36'(xy_q) - 36'(zw_q)) <<< 1;
    m28[0][2] = (36'(xz_q) + 36'(yw_q)) <<< 1;
    m28[1][0] = (36'(xy_q) + 36'(zw_q)) <<< 1;
    m28[1][1] = ONE - ((36'(xx_q) + 36'(zz_q)) <<< 1);
    m28[1][2] = (36'(yz_q) - 36'(xw_q)) <<< 1;
    m28[2][0] = (36'(xz_q) - 36'(yw_q)) <<< 1;
    m28[2][1] = (36'(yz_q) + 36'(xw_q)) <<< 1;
    m28[2][2] = ONE - ((36'(xx_q) + 36'(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_q[i][j] <= 32'((m28[i][j] + 36'sd8) >>> 4);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q[0] <= point_i.point_x;
    p1_q[1] <= point_i.point_y;
    p1_q[2] <= point_i.point_z;
    p2_q    <= p1_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_q[i][j] <= m_q[i][j] * p2_q[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 66'(pp_q[i][0]) + 66'(pp_q[i][1]) + 66'(pp_q[i][2]) + 66'sd8388608;
      sh[i]  = acc[i] >>> 24;
      sat[i] = sat32(68'(sh[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
    end else begin
      rot_q.vld  <= v3_q;
      rot_q.rx   <= sat[0][31:0];
      rot_q.ry   <= sat[1][31:0];
      rot_q.rz   <= sat[2][31:0];
      rot_q.flag <= sat[0][32] | sat[1][32] | sat[2][32];
    end
  end

  assign rot_o = rot_q;

endmodule

>>> src/qvt_scale.sv
module qvt_scale import qvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  qvt_cfg_t  cfg_i,
  input  qvt_rot_t  rot_i,
  output qvt_proj_t proj_o
);

  qvt_rot_t           a_q, b_q;
  logic signed [63:0] prod_q [3];
  logic signed [64:0] t [3];
  logic signed [64:0] sh [3];
  logic        [32:0] sat [3];
  logic signed [31:0] s_q [3];
  logic               sflag_q;
  logic signed [32:0] vs;
  qvt_proj_t          proj_q;

  assign vs = $signed({1'b0, cfg_i.view_scale});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else begin
      a_q <= rot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0] <= 64'(rot_i.rx * vs);
    prod_q[1] <= 64'(rot_i.ry * vs);
    prod_q[2] <= 64'(rot_i.rz * vs);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]   = 65'(prod_q[i]) + 65'sd32768;
      sh[i]  = t[i] >>> 16;
      sat[i] = sat32(68'(sh[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else begin
      b_q <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s_q[i] <= sat[i][31:0];
    end
    sflag_q <= sat[0][32] | sat[1][32] | sat[2][32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q <= '0;
    end else begin
      proj_q.vld   <= b_q.vld;
      proj_q.rx    <= b_q.rx;
      proj_q.ry    <= b_q.ry;
      proj_q.rz    <= b_q.rz;
      proj_q.sx    <= s_q[0];
      proj_q.sy    <= s_q[1];
      proj_q.sz    <= s_q[2];
      proj_q.flag  <= b_q.flag | sflag_q;
      proj_q.persp <= cfg_i.perspective_on;
      proj_q.num_x <= s_q[0] * cfg_i.focal_length;
      proj_q.num_y <= s_q[1] * cfg_i.focal_length;
      proj_q.denom <= 33'(cfg_i.eye_distance) + 33'(s_q[2]);
    end
  end

  assign proj_o = proj_q;

endmodule

>>> src/qvt_div_stage.sv
module qvt_div_stage import qvt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  qvt_div_t d_i,
  output qvt_div_t d_o
);

  qvt_div_t       n;
  logic [DVS_W:0] r;
  logic           qbit;
  qvt_div_t       d_q;

  always_comb begin
    n = d_i;
    r = '0;
    qbit = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r     = {n.rem, n.dvd[DIV_BITS-1]};
      n.dvd = n.dvd << 1;
      qbit  = (r >= {1'b0, n.dvs});
      if (qbit) begin
        r = r - {1'b0, n.dvs};
      end
      n.rem = r[DVS_W-1:0];
      n.quo = {n.quo[DIV_BITS-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else begin
      d_q <= n;
    end
  end

  assign d_o = d_q;

endmodule
